FILE: design/itp_pkg.sv
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned PREC_W      = 2;

  localparam logic [CODE_W-1:0] CODE_RPAREN = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MUL    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DIV    = 3'd4;
  localparam logic [CODE_W-1:0] CODE_POW    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_NONE   = 3'd7;

  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL    = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV    = 8'h2F;
  localparam logic [SYM_W-1:0] CH_POW    = 8'h5E;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic latch;
    logic pop;
    logic push;
    logic emit_top;
    logic emit_sym;
    logic emit_term;
    logic move_out;
    logic last;
  } itp_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic is_alnum;
    logic is_rparen;
    logic is_lparen;
    logic is_op;
    logic empty;
    logic top_rparen;
    logic top_pops;
    logic out_free;
    logic pend_valid;
  } itp_sts_t;

  function automatic logic [CODE_W-1:0] op_code(input logic [SYM_W-1:0] ch);
    logic [CODE_W-1:0] c;
    case (ch)
      CH_PLUS:  c = CODE_PLUS;
      CH_MINUS: c = CODE_MINUS;
      CH_MUL:   c = CODE_MUL;
      CH_DIV:   c = CODE_DIV;
      CH_POW:   c = CODE_POW;
      default:  c = CODE_NONE;
    endcase
    return c;
  endfunction

  // ')' ranks below every operator, so it takes the lowest code
  function automatic logic [PREC_W-1:0] op_prec(input logic [CODE_W-1:0] c);
    logic [PREC_W-1:0] p;
    case (c)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_POW:              p = 2'd3;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [SYM_W-1:0] op_char(input logic [CODE_W-1:0] c);
    logic [SYM_W-1:0] ch;
    case (c)
      CODE_RPAREN: ch = CH_RPAREN;
      CODE_PLUS:   ch = CH_PLUS;
      CODE_MINUS:  ch = CH_MINUS;
      CODE_MUL:    ch = CH_MUL;
      CODE_DIV:    ch = CH_DIV;
      CODE_POW:    ch = CH_POW;
      default:     ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_alnum(input logic [SYM_W-1:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

endpackage

FILE: design/itp_datapath.sv
module itp_datapath import itp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itp_cmd_t         cmd_i,
  output itp_sts_t         sts_o,
  input  logic [SYM_W-1:0] in_symbol_i,
  input  logic             in_flush_i,
  output logic [SYM_W-1:0] out_symbol_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_last_o,
  output logic             out_done_o,
  output logic             out_ovf_o
);

  logic [CODE_W-1:0] stack_q [STACK_DEPTH];
  logic [CODE_W-1:0] top_q;
  logic [CNT_W-1:0]  count_q;
  logic              ovf_q;
  logic [SYM_W-1:0]  sym_q;
  logic              flush_q;
  logic              pend_valid_q;
  logic [SYM_W-1:0]  pend_sym_q;
  logic              pend_done_q;
  logic              out_valid_q;
  logic [SYM_W-1:0]  out_sym_q;
  logic              out_last_q;
  logic              out_done_q;
  logic              out_ovf_q;

  logic [CNT_W-1:0]  below_idx;
  logic [CODE_W-1:0] top_code;
  logic [CODE_W-1:0] in_code;
  logic [CODE_W-1:0] push_code;
  logic [PREC_W-1:0] top_prec;
  logic [PREC_W-1:0] in_prec;

  assign below_idx = count_q - CNT_W'(2);
  assign top_code  = top_q;
  assign in_code   = op_code(sym_q);
  assign top_prec  = op_prec(top_code);
  assign in_prec   = op_prec(in_code);
  assign push_code = (sym_q == CH_RPAREN) ? CODE_RPAREN : in_code;

  always_comb begin
    sts_o            = '0;
    sts_o.is_flush   = flush_q;
    sts_o.is_alnum   = !flush_q && is_alnum(sym_q);
    sts_o.is_rparen  = !flush_q && (sym_q == CH_RPAREN);
    sts_o.is_lparen  = !flush_q && (sym_q == CH_LPAREN);
    sts_o.is_op      = !flush_q && (in_code != CODE_NONE);
    sts_o.empty      = (count_q == '0);
    sts_o.top_rparen = (top_code == CODE_RPAREN);
    sts_o.top_pops   = (top_prec > in_prec) ||
                       ((top_prec == in_prec) && (in_code == CODE_POW));
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.pend_valid = pend_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sym_q   <= in_symbol_i;
      flush_q <= in_flush_i;
    end
    if (cmd_i.push && (count_q != CNT_W'(STACK_DEPTH))) begin
      stack_q[count_q[PTR_W-1:0]] <= push_code;
    end
    // top entry kept in a register; a pop reloads it from the entry below
    if (cmd_i.pop) begin
      top_q <= stack_q[below_idx[PTR_W-1:0]];
    end else if (cmd_i.push && (count_q != CNT_W'(STACK_DEPTH))) begin
      top_q <= push_code;
    end
    if (cmd_i.emit_top || cmd_i.emit_sym || cmd_i.emit_term) begin
      pend_done_q <= cmd_i.emit_term;
      if (cmd_i.emit_top) begin
        pend_sym_q <= op_char(top_code);
      end else if (cmd_i.emit_sym) begin
        pend_sym_q <= sym_q;
      end else begin
        pend_sym_q <= CH_NUL;
      end
    end
    if (cmd_i.move_out) begin
      out_sym_q  <= pend_sym_q;
      out_done_q <= pend_done_q;
      out_last_q <= cmd_i.last;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pop) begin
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.push) begin
        if (count_q == CNT_W'(STACK_DEPTH)) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.emit_top || cmd_i.emit_sym || cmd_i.emit_term) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.move_out) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.move_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;
  assign out_done_o   = out_done_q;
  assign out_ovf_o    = out_ovf_q;

endmodule

FILE: design/itp_ctrl.sv
module itp_ctrl import itp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  itp_sts_t sts_i,
  output itp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       can_emit;

  assign in_ready_o = (state_q == ST_IDLE);
  // a new result may enter the holding slot once the old one can leave
  assign can_emit   = !sts_i.pend_valid || sts_i.out_free;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.is_flush) begin
          if (!sts_i.empty) begin
            if (sts_i.top_rparen) begin
              cmd_o.pop = 1'b1;
            end else if (can_emit) begin
              cmd_o.pop      = 1'b1;
              cmd_o.emit_top = 1'b1;
              cmd_o.move_out = sts_i.pend_valid;
            end
          end else if (can_emit) begin
            cmd_o.emit_term = 1'b1;
            cmd_o.move_out  = sts_i.pend_valid;
            state_d         = ST_END;
          end
        end else if (sts_i.is_alnum) begin
          cmd_o.emit_sym = 1'b1;
          state_d        = ST_END;
        end else if (sts_i.is_rparen) begin
          cmd_o.push = 1'b1;
          state_d    = ST_END;
        end else if (sts_i.is_lparen) begin
          if (!sts_i.empty && !sts_i.top_rparen) begin
            if (can_emit) begin
              cmd_o.pop      = 1'b1;
              cmd_o.emit_top = 1'b1;
              cmd_o.move_out = sts_i.pend_valid;
            end
          end else begin
            cmd_o.pop = !sts_i.empty;
            state_d   = ST_END;
          end
        end else if (sts_i.is_op) begin
          if (!sts_i.empty && sts_i.top_pops) begin
            if (can_emit) begin
              cmd_o.pop      = 1'b1;
              cmd_o.emit_top = 1'b1;
              cmd_o.move_out = sts_i.pend_valid;
            end
          end else begin
            cmd_o.push = 1'b1;
            state_d    = ST_END;
          end
        end else begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.move_out = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/infix_to_prefix_converter_unit.sv
// Infix to prefix converter. Feed the infix expression one ASCII character per
// transaction, rightmost character first, and end it with a transaction whose
// tuser (flush) is 1. Letters and digits are passed on, operators are reordered
// through a 32-entry operator stack, and the prefix expression comes out read
// from its last character to its first, closed by a terminator transaction with
// tdata 0 and expression_done set. tlast marks the last result of each input
// transaction. An input passes the controller states idle, run and end, staying
// in run for each operator it emits from the stack and, on a flush, for each
// ')' it drops, one pop per cycle from the stack's top entry; a stalled output
// holds the controller. A push onto a full stack is dropped and the sticky
// overflow flag, reported on every result, stays set until reset.
module infix_to_prefix_converter_unit import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tuser,   // [0] flush
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [0] expression_done, [1] overflow_seen
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_symbol_i  (s_axis_tdata),
    .in_flush_i   (s_axis_tuser),
    .out_symbol_o (m_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser[0]),
    .out_ovf_o    (m_axis_tuser[1])
  );

endmodule
